### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that holds at every clock edge outside reset.
`define RFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define RFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rfb_pkg.sv
`timescale 1ns / 1ps
package rfb_pkg;

  localparam int OP_W     = 4;
  localparam int IDX_W    = 7;
  localparam int LVL_W    = 8;
  localparam int PCT_W    = 7;
  localparam int CNT_W    = 8;
  localparam int SLOT_W   = 10;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXTURES = 4'd1;

  localparam logic [SLOT_W-1:0] BASE_RESET  = 10'd1;
  localparam logic [LVL_W-1:0]  PCT_LIMIT   = 8'd100;
  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;
  localparam logic [LVL_W-1:0]  LEVEL_FULL  = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 4'd0,
    OP_RED    = 4'd1,
    OP_GREEN  = 4'd2,
    OP_BLUE   = 4'd3,
    OP_COLOUR = 4'd4,
    OP_BRIGHT = 4'd5,
    OP_TEMP   = 4'd6,
    OP_POWER  = 4'd7,
    OP_RESET  = 4'd8
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_PERCENT = 2'd2
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] fixture_index;
    logic [LVL_W-1:0] red_in;
    logic [LVL_W-1:0] green_in;
    logic [LVL_W-1:0] blue_in;
    logic [LVL_W-1:0] level_percent;
    logic             power_on;
  } cmd_t;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
    logic [LVL_W-1:0] white;
    logic [PCT_W-1:0] bright;
    logic [PCT_W-1:0] temp;
    logic             power;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    red: LEVEL_FULL, green: LEVEL_FULL, blue: LEVEL_FULL, white: LEVEL_FULL,
    bright: PCT_FULL, temp: PCT_FULL, power: 1'b1
  };

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LVL_W-1:0]  actual_red;
    logic [LVL_W-1:0]  actual_green;
    logic [LVL_W-1:0]  actual_blue;
    logic [LVL_W-1:0]  actual_white;
    logic              actual_lit;
    logic              power_requested;
    logic [PCT_W-1:0]  brightness_now;
    logic [PCT_W-1:0]  temperature_now;
    logic [SLOT_W-1:0] dmx_slot;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic read;
    logic modify;
    logic write_en;
    logic scale;
    logic load_out;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_range;
  } sts_t;

endpackage

### rtl/rfb_in_if.sv
`timescale 1ns / 1ps
interface rfb_in_if
  import rfb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] fixture_index;
  logic [LVL_W-1:0] red_in;
  logic [LVL_W-1:0] green_in;
  logic [LVL_W-1:0] blue_in;
  logic [LVL_W-1:0] level_percent;
  logic             power_on;

  modport source (output valid, opcode, fixture_index, red_in, green_in, blue_in,
                  level_percent, power_on, input ready);
  modport sink (input valid, opcode, fixture_index, red_in, green_in, blue_in,
                level_percent, power_on, output ready);
endinterface

### rtl/rfb_out_if.sv
`timescale 1ns / 1ps
interface rfb_out_if
  import rfb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [LVL_W-1:0]  actual_red;
  logic [LVL_W-1:0]  actual_green;
  logic [LVL_W-1:0]  actual_blue;
  logic [LVL_W-1:0]  actual_white;
  logic              actual_lit;
  logic              power_requested;
  logic [PCT_W-1:0]  brightness_now;
  logic [PCT_W-1:0]  temperature_now;
  logic [SLOT_W-1:0] dmx_slot;

  modport source (output valid, status, actual_red, actual_green, actual_blue,
                  actual_white, actual_lit, power_requested, brightness_now,
                  temperature_now, dmx_slot, input ready);
  modport sink (input valid, status, actual_red, actual_green, actual_blue,
                actual_white, actual_lit, power_requested, brightness_now,
                temperature_now, dmx_slot, output ready);
endinterface

### rtl/rfb_cfg_if.sv
`timescale 1ns / 1ps
interface rfb_cfg_if
  import rfb_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/rfb_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfb_ctrl
  import rfb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MODIFY,
    S_SCALE,
    S_DIVIDE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready     = (state_r == S_IDLE);
    ctl.capture  = in_valid && in_ready;
    ctl.read     = (state_r == S_READ);
    ctl.modify   = (state_r == S_MODIFY);
    ctl.write_en = (state_r == S_MODIFY) && sts.in_range;
    ctl.scale    = (state_r == S_SCALE);
    // hold the finished item until the result register frees up
    ctl.load_out = (state_r == S_DIVIDE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (ctl.capture) state_nxt = S_READ;
      S_READ:   state_nxt = S_MODIFY;
      S_MODIFY: state_nxt = S_SCALE;
      S_SCALE:  state_nxt = S_DIVIDE;
      S_DIVIDE: if (ctl.load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RFB_ASSERT(a_rise_from_divide, $rose(out_valid_r) |-> $past(state_r == S_DIVIDE), "result appeared outside divide step")
  `RFB_ASSERT_NEXT(a_accept_reads, ctl.capture, state_r == S_READ, "accepted item did not start a read")
  `RFB_ASSERT(a_single_item, (state_r != S_IDLE) |-> !ctl.capture, "item accepted while busy")

endmodule

### rtl/rfb_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfb_datapath
  import rfb_pkg::*;
#(
  parameter int MAX_FIXTURES = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  input  cmd_t                  cmd_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               result
);

  localparam int AW = (MAX_FIXTURES > 1) ? $clog2(MAX_FIXTURES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FIXTURES);
  localparam int PROD_W  = LVL_W + PCT_W;
  localparam int RECIP_W = 13;
  localparam int SHIFT   = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam logic [PROD_W-1:0]  LEVEL_MUL = PROD_W'(255);
  localparam logic [PROD_W-1:0]  ROUND_ADD = PROD_W'(50);

  // x / 100 for x below 43699, via reciprocal multiply
  function automatic logic [LVL_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [PROD_W+RECIP_W-1:0] p;
    p = (PROD_W+RECIP_W)'(x) * (PROD_W+RECIP_W)'(RECIP_100);
    return p[SHIFT +: LVL_W];
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] n);
    return (n > MAX_CNT) ? MAX_CNT : n;
  endfunction

  logic [$bits(entry_t)-1:0] mem [MAX_FIXTURES];

  cmd_t                  cmd_r;
  logic [SLOT_W-1:0]     base_r;
  logic [CNT_W-1:0]      fixtures_r;
  logic [MAX_FIXTURES-1:0] valid_r, valid_nxt;
  entry_t                rd_r;
  logic                  hit_r;
  logic                  range_r;
  logic [PROD_W-1:0]     wsum_r;
  entry_t                ent_r, ent_mod;
  status_t               stat_r, stat_mod;
  logic [PROD_W-1:0]     prod_r [4];
  result_t               res_r, res_nxt;

  logic [AW-1:0]         addr;
  logic                  cfg_fix_we;
  logic [CNT_W-1:0]      old_n, new_n, lo_n;
  entry_t                cur;
  logic                  pct_bad;
  logic [LVL_W-1:0]      act [4];

  assign addr       = cmd_r.fixture_index[AW-1:0];
  assign cfg_fix_we = cfg_we && (cfg_index == REG_FIXTURES);
  assign old_n      = clamp_cnt(fixtures_r);
  assign new_n      = clamp_cnt(cfg_data[CNT_W-1:0]);
  assign lo_n       = (old_n < new_n) ? old_n : new_n;
  assign sts.in_range = range_r;

  always_ff @(posedge clk) begin
    if (ctl.write_en) begin
      mem[addr] <= ent_mod;
    end
    rd_r <= entry_t'(mem[addr]);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.write_en) begin
      valid_nxt[addr] = 1'b1;
    end
    // drop entries at or above the smaller count so they read as fresh
    if (cfg_fix_we) begin
      for (int i = 0; i < MAX_FIXTURES; i++) begin
        if (CNT_W'(i) >= lo_n) valid_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= BASE_RESET;
      fixtures_r <= '0;
      valid_r    <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_BASE)) base_r <= cfg_data[SLOT_W-1:0];
      if (cfg_fix_we) fixtures_r <= cfg_data[CNT_W-1:0];
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    cur      = hit_r ? rd_r : ENTRY_RESET;
    ent_mod  = cur;
    stat_mod = ST_OK;
    pct_bad  = cmd_r.level_percent > PCT_LIMIT;
    case (opcode_t'(cmd_r.opcode))
      OP_RED: begin
        ent_mod.red   = cmd_r.red_in;
        ent_mod.white = '0;
      end
      OP_GREEN: begin
        ent_mod.green = cmd_r.green_in;
        ent_mod.white = '0;
      end
      OP_BLUE: begin
        ent_mod.blue  = cmd_r.blue_in;
        ent_mod.white = '0;
      end
      OP_COLOUR: begin
        ent_mod.red   = cmd_r.red_in;
        ent_mod.green = cmd_r.green_in;
        ent_mod.blue  = cmd_r.blue_in;
        ent_mod.white = '0;
      end
      OP_BRIGHT: begin
        if (pct_bad) stat_mod = ST_PERCENT;
        else ent_mod.bright = cmd_r.level_percent[PCT_W-1:0];
      end
      OP_TEMP: begin
        if (pct_bad) begin
          stat_mod = ST_PERCENT;
        end else begin
          ent_mod.temp  = cmd_r.level_percent[PCT_W-1:0];
          ent_mod.red   = LEVEL_FULL;
          ent_mod.green = LEVEL_FULL;
          ent_mod.blue  = LEVEL_FULL;
          ent_mod.white = div100(wsum_r);
        end
      end
      OP_POWER: ent_mod.power = cmd_r.power_on;
      OP_RESET: ent_mod = ENTRY_RESET;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= cmd_in;
    end
    if (ctl.read) begin
      hit_r   <= valid_r[addr];
      range_r <= {1'b0, cmd_r.fixture_index} < clamp_cnt(fixtures_r);
      wsum_r  <= PROD_W'(cmd_r.level_percent) * LEVEL_MUL + ROUND_ADD;
    end
    if (ctl.modify) begin
      ent_r  <= ent_mod;
      stat_r <= stat_mod;
    end
    if (ctl.scale) begin
      prod_r[0] <= PROD_W'(ent_r.red)   * PROD_W'(ent_r.bright);
      prod_r[1] <= PROD_W'(ent_r.green) * PROD_W'(ent_r.bright);
      prod_r[2] <= PROD_W'(ent_r.blue)  * PROD_W'(ent_r.bright);
      prod_r[3] <= PROD_W'(ent_r.white) * PROD_W'(ent_r.bright);
    end
    if (ctl.load_out) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      act[k] = ent_r.power ? div100(prod_r[k]) : '0;
    end
    res_nxt = '0;
    if (!range_r) begin
      res_nxt.status = ST_RANGE;
    end else begin
      res_nxt.status          = stat_r;
      res_nxt.actual_red      = act[0];
      res_nxt.actual_green    = act[1];
      res_nxt.actual_blue     = act[2];
      res_nxt.actual_white    = act[3];
      res_nxt.actual_lit      = (act[0] != '0) || (act[1] != '0) ||
                                (act[2] != '0) || (act[3] != '0);
      res_nxt.power_requested = ent_r.power;
      res_nxt.brightness_now  = ent_r.bright;
      res_nxt.temperature_now = ent_r.temp;
      res_nxt.dmx_slot        = base_r + SLOT_W'({cmd_r.fixture_index, 2'b00});
    end
  end

  assign result = res_r;

  `RFB_ASSERT_NEXT(a_write_marks_valid, ctl.write_en && !cfg_fix_we, valid_r[addr], "written entry not marked valid")
  `RFB_ASSERT_NEXT(a_range_result, ctl.load_out && !range_r, (res_r.status == ST_RANGE) && (res_r.dmx_slot == '0), "out of range result not cleared")
  `RFB_ASSERT(a_write_in_range, ctl.write_en |-> ctl.modify, "entry written outside update step")

endmodule

### rtl/rgbw_fixture_bank_top.sv
`timescale 1ns / 1ps
// RGBW fixture bank: one command item in, one result item out. Each item passes through
// the controller steps capture, entry read from the fixture memory, update and write-back,
// brightness multiply and divide by 100, and the result register loads in the divide step.
// The controller handles one item at a time, so the input reopens the cycle after the
// result is loaded and no new item is taken before the last one is through. A result
// waiting to be taken stalls only the final step.
// Configuration writes are taken every cycle; fixture entries restored to defaults
// by reset or a count change are marked by per-entry valid bits, with no clearing
// pass.
module rgbw_fixture_bank_top
  import rfb_pkg::*;
#(
  parameter int MAX_FIXTURES = 128
) (
  input logic       clk,
  input logic       rst_n,
  rfb_in_if.sink    in_ch,
  rfb_out_if.source out_ch,
  rfb_cfg_if.sink   cfg_ch
);

  ctl_t    ctl;
  sts_t    sts;
  cmd_t    cmd_in;
  result_t result;

  assign cmd_in = '{
    opcode:        in_ch.opcode,
    fixture_index: in_ch.fixture_index,
    red_in:        in_ch.red_in,
    green_in:      in_ch.green_in,
    blue_in:       in_ch.blue_in,
    level_percent: in_ch.level_percent,
    power_on:      in_ch.power_on
  };

  assign cfg_ch.ready = 1'b1;

  rfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  rfb_datapath #(
    .MAX_FIXTURES (MAX_FIXTURES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .cmd_in    (cmd_in),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .result    (result)
  );

  assign out_ch.status          = result.status;
  assign out_ch.actual_red      = result.actual_red;
  assign out_ch.actual_green    = result.actual_green;
  assign out_ch.actual_blue     = result.actual_blue;
  assign out_ch.actual_white    = result.actual_white;
  assign out_ch.actual_lit      = result.actual_lit;
  assign out_ch.power_requested = result.power_requested;
  assign out_ch.brightness_now  = result.brightness_now;
  assign out_ch.temperature_now = result.temperature_now;
  assign out_ch.dmx_slot        = result.dmx_slot;

endmodule

### dv/rgbw_fixture_bank_checker.sv
`timescale 1ns / 1ps
module rgbw_fixture_bank_checker
  import rfb_pkg::*;
#(
  parameter int MAX_FIXTURES = 128
) (
  input  logic clk,
  input  logic rst_n,
  rfb_in_if    in_ch,
  rfb_out_if   out_ch,
  rfb_cfg_if   cfg_ch,
  output int   mismatches,
  output int   outstanding,
  output int   results_checked,
  output int   rejected
);

  entry_t            bank [MAX_FIXTURES];
  logic [SLOT_W-1:0] dmx_base;
  logic [CNT_W-1:0]  count_cfg;
  result_t           pending_results [$];

  cmd_t        cmd_seen;
  result_t     got;
  result_t     want;
  int unsigned old_n;
  int unsigned new_n;
  int unsigned first_cleared;

  function automatic int unsigned live_fixtures(logic [CNT_W-1:0] n);
    return (n > MAX_FIXTURES) ? MAX_FIXTURES : n;
  endfunction

  function automatic logic [LVL_W-1:0] dimmed(logic [LVL_W-1:0] lvl,
                                              logic [PCT_W-1:0] pct, logic on);
    int unsigned prod;
    prod = int'(lvl) * int'(pct);
    return on ? LVL_W'(prod / 100) : '0;
  endfunction

  // Update the addressed fixture and return the levels it shows afterwards.
  function automatic result_t execute_command(cmd_t c);
    result_t r;
    entry_t  e;
    r = '0;
    if (c.fixture_index >= live_fixtures(count_cfg)) begin
      r.status = ST_RANGE;
      return r;
    end
    e = bank[c.fixture_index];
    r.status = ST_OK;
    case (c.opcode)
      OP_RED:    begin e.red = c.red_in; e.white = '0; end
      OP_GREEN:  begin e.green = c.green_in; e.white = '0; end
      OP_BLUE:   begin e.blue = c.blue_in; e.white = '0; end
      OP_COLOUR: begin
        e.red   = c.red_in;
        e.green = c.green_in;
        e.blue  = c.blue_in;
        e.white = '0;
      end
      OP_BRIGHT: begin
        if (c.level_percent > PCT_LIMIT) r.status = ST_PERCENT;
        else e.bright = c.level_percent[PCT_W-1:0];
      end
      OP_TEMP: begin
        if (c.level_percent > PCT_LIMIT) begin
          r.status = ST_PERCENT;
        end else begin
          e.temp  = c.level_percent[PCT_W-1:0];
          e.red   = LEVEL_FULL;
          e.green = LEVEL_FULL;
          e.blue  = LEVEL_FULL;
          // white is the percent of full scale, rounded half up
          e.white = LVL_W'((int'(c.level_percent) * 255 + 50) / 100);
        end
      end
      OP_POWER:  e.power = c.power_on;
      OP_RESET:  e = ENTRY_RESET;
      default:   ;
    endcase
    bank[c.fixture_index] = e;
    r.actual_red      = dimmed(e.red, e.bright, e.power);
    r.actual_green    = dimmed(e.green, e.bright, e.power);
    r.actual_blue     = dimmed(e.blue, e.bright, e.power);
    r.actual_white    = dimmed(e.white, e.bright, e.power);
    r.actual_lit      = |{r.actual_red, r.actual_green, r.actual_blue, r.actual_white};
    r.power_requested = e.power;
    r.brightness_now  = e.bright;
    r.temperature_now = e.temp;
    // wraps modulo 1024 at slot width
    r.dmx_slot        = dmx_base + {c.fixture_index, 2'b00};
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_FIXTURES; i++) bank[i] = ENTRY_RESET;
      dmx_base        = BASE_RESET;
      count_cfg       = '0;
      pending_results.delete();
      mismatches      = 0;
      results_checked = 0;
      rejected        = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_BASE: dmx_base = cfg_ch.data;
          REG_FIXTURES: begin
            old_n = live_fixtures(count_cfg);
            new_n = live_fixtures(cfg_ch.data[CNT_W-1:0]);
            first_cleared = (old_n < new_n) ? old_n : new_n;
            // removed and newly added fixtures start from defaults
            for (int i = int'(first_cleared); i < MAX_FIXTURES; i++) bank[i] = ENTRY_RESET;
            count_cfg = cfg_ch.data[CNT_W-1:0];
          end
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got.status          = out_ch.status;
        got.actual_red      = out_ch.actual_red;
        got.actual_green    = out_ch.actual_green;
        got.actual_blue     = out_ch.actual_blue;
        got.actual_white    = out_ch.actual_white;
        got.actual_lit      = out_ch.actual_lit;
        got.power_requested = out_ch.power_requested;
        got.brightness_now  = out_ch.brightness_now;
        got.temperature_now = out_ch.temperature_now;
        got.dmx_slot        = out_ch.dmx_slot;
        if (pending_results.size() == 0) begin
          $error("result item with no command waiting");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", want.status, got.status);
          compare_field("actual_red", want.actual_red, got.actual_red);
          compare_field("actual_green", want.actual_green, got.actual_green);
          compare_field("actual_blue", want.actual_blue, got.actual_blue);
          compare_field("actual_white", want.actual_white, got.actual_white);
          compare_field("actual_lit", want.actual_lit, got.actual_lit);
          compare_field("power_requested", want.power_requested, got.power_requested);
          compare_field("brightness_now", want.brightness_now, got.brightness_now);
          compare_field("temperature_now", want.temperature_now, got.temperature_now);
          compare_field("dmx_slot", want.dmx_slot, got.dmx_slot);
          results_checked++;
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        cmd_seen.opcode        = in_ch.opcode;
        cmd_seen.fixture_index = in_ch.fixture_index;
        cmd_seen.red_in        = in_ch.red_in;
        cmd_seen.green_in      = in_ch.green_in;
        cmd_seen.blue_in       = in_ch.blue_in;
        cmd_seen.level_percent = in_ch.level_percent;
        cmd_seen.power_on      = in_ch.power_on;
        want = execute_command(cmd_seen);
        if (want.status != ST_OK) rejected++;
        pending_results.push_back(want);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

### dv/rgbw_fixture_bank_top_tb.sv
`timescale 1ns / 1ps
module rgbw_fixture_bank_top_tb;
  import rfb_pkg::*;

  localparam int MAX_FIXTURES = 128;
  localparam int STALL_LIMIT  = 3000;
  localparam int IDLE_LIGHT   = 15;
  localparam int IDLE_HEAVY   = 77;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 4'd15;
  localparam logic [OP_W-1:0]      OP_SPARE_LO = 4'd9;
  localparam logic [OP_W-1:0]      OP_SPARE_HI = 4'd15;

  logic clk;
  logic rst_n;

  rfb_in_if  in_if ();
  rfb_out_if out_if ();
  rfb_cfg_if cfg_if ();

  int mismatches;
  int outstanding;
  int results_checked;
  int rejected;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned commands_sent;
  int unsigned settings_used;
  int unsigned quiet_cycles;

  rgbw_fixture_bank_top #(.MAX_FIXTURES(MAX_FIXTURES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  rgbw_fixture_bank_checker #(.MAX_FIXTURES(MAX_FIXTURES)) fixture_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_if),
    .out_ch          (out_if),
    .cfg_ch          (cfg_if),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .rejected        (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // End the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("rgbw_fixture_bank_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cmd_t make_cmd(logic [OP_W-1:0] op, int unsigned idx,
                                    int unsigned r, int unsigned g, int unsigned b,
                                    int unsigned pct, bit pwr);
    cmd_t c;
    c.opcode        = op;
    c.fixture_index = IDX_W'(idx);
    c.red_in        = LVL_W'(r);
    c.green_in      = LVL_W'(g);
    c.blue_in       = LVL_W'(b);
    c.level_percent = LVL_W'(pct);
    c.power_on      = pwr;
    return c;
  endfunction

  // Favor a few fixtures so that commands pile up on the same entries.
  function automatic cmd_t random_cmd(int unsigned live);
    cmd_t        c;
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(0, 99);
    if (live == 0 || roll >= 92) pick = $urandom_range(0, MAX_FIXTURES - 1);
    else if (roll < 45) pick = $urandom_range(0, (live < 4 ? live : 4) - 1);
    else if (roll < 85) pick = $urandom_range(0, live - 1);
    else pick = live - 1;
    c.fixture_index = IDX_W'(pick);
    if ($urandom_range(0, 99) < 93) c.opcode = OP_W'($urandom_range(OP_READ, OP_RESET));
    else c.opcode = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    c.red_in   = LVL_W'($urandom_range(0, 255));
    c.green_in = LVL_W'($urandom_range(0, 255));
    c.blue_in  = LVL_W'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 75) c.level_percent = LVL_W'($urandom_range(0, PCT_LIMIT));
    else if (roll < 82) c.level_percent = PCT_LIMIT;
    else c.level_percent = LVL_W'($urandom_range(PCT_LIMIT + 1, 255));
    c.power_on = ($urandom_range(0, 99) < 80);
    return c;
  endfunction

  task automatic send_cmd(cmd_t c);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= c.opcode;
    in_if.fixture_index <= c.fixture_index;
    in_if.red_in        <= c.red_in;
    in_if.green_in      <= c.green_in;
    in_if.blue_in       <= c.blue_in;
    in_if.level_percent <= c.level_percent;
    in_if.power_on      <= c.power_on;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    commands_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold off until every result is back, plus the pipeline depth.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned base, int unsigned count_word, int unsigned n_items,
                           int unsigned send_pct, int unsigned recv_pct);
    int unsigned live;
    wait_idle();
    write_reg(REG_BASE, base);
    write_reg(REG_FIXTURES, count_word);
    settings_used++;
    live = count_word & 8'hFF;
    if (live > MAX_FIXTURES) live = MAX_FIXTURES;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_items) send_cmd(random_cmd(live));
  endtask

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.opcode        = OP_READ;
    in_if.fixture_index = '0;
    in_if.red_in        = '0;
    in_if.green_in      = '0;
    in_if.blue_in       = '0;
    in_if.level_percent = '0;
    in_if.power_on      = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_BASE;
    cfg_if.data         = '0;
    send_idle_pct       = IDLE_LIGHT;
    recv_idle_pct       = IDLE_HEAVY;
    commands_sent       = 0;
    settings_used       = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no fixtures after reset: everything is out of range, even a bad percent
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_BRIGHT, 127, 0, 0, 0, 200, 1'b1));
    wait_idle();
    write_reg(REG_SPARE, 10'h3FF);
    write_reg(REG_BASE, 512);
    write_reg(REG_FIXTURES, 4);
    settings_used++;
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_READ, 3, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_READ, 4, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_READ, 127, 255, 255, 255, 255, 1'b1));
    send_cmd(make_cmd(OP_RED, 0, 0, 255, 255, 0, 1'b0));
    send_cmd(make_cmd(OP_GREEN, 0, 0, 255, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_BLUE, 0, 255, 0, 128, 0, 1'b0));
    send_cmd(make_cmd(OP_COLOUR, 1, 255, 0, 170, 0, 1'b0));
    send_cmd(make_cmd(OP_BRIGHT, 1, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_BRIGHT, 1, 0, 0, 0, 101, 1'b0));
    send_cmd(make_cmd(OP_BRIGHT, 1, 0, 0, 0, 255, 1'b0));
    send_cmd(make_cmd(OP_BRIGHT, 1, 0, 0, 0, 100, 1'b0));
    send_cmd(make_cmd(OP_BRIGHT, 2, 0, 0, 0, 50, 1'b0));
    send_cmd(make_cmd(OP_TEMP, 2, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_TEMP, 2, 0, 0, 0, 100, 1'b0));
    send_cmd(make_cmd(OP_TEMP, 2, 0, 0, 0, 101, 1'b0));
    send_cmd(make_cmd(OP_TEMP, 3, 0, 0, 0, 1, 1'b0));
    send_cmd(make_cmd(OP_TEMP, 3, 0, 0, 0, 99, 1'b0));
    send_cmd(make_cmd(OP_POWER, 0, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_POWER, 0, 0, 0, 0, 0, 1'b1));
    send_cmd(make_cmd(OP_RESET, 1, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_SPARE_LO, 1, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_SPARE_HI, 2, 0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_COLOUR, 3, 0, 0, 0, 0, 1'b1));

    run_phase(1, 128, 130, IDLE_LIGHT, IDLE_HEAVY);
    run_phase(700, 1, 100, IDLE_LIGHT, IDLE_HEAVY);
    run_phase(1000, 128, 140, IDLE_LIGHT, IDLE_HEAVY);
    run_phase(37, 255, 140, IDLE_HEAVY, IDLE_LIGHT);
    run_phase(1023, 10'h303, 120, IDLE_HEAVY, IDLE_LIGHT);
    run_phase(300, 64, 130, IDLE_HEAVY, IDLE_LIGHT);
    run_phase(512, 127, 140, 0, 0);
    run_phase(1, 0, 30, 0, 0);
    run_phase(2, 128, 200, 0, 0);
    wait_idle();

    $display("Ran %0d commands over %0d register settings, %0d rejected for range or percent.",
             commands_sent, settings_used, rejected);
    $display("Compared %0d result items field by field, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("rgbw_fixture_bank_top regression: pass");
    end else begin
      $display("rgbw_fixture_bank_top regression: fail");
    end
    $finish;
  end

endmodule
